// ===== rtl/core/epdsf_pkg.sv =====
`timescale 1ns / 1ps

package epdsf_pkg;

	// Fixed field widths
	localparam int PIX_W   = 16;
	localparam int ROW_W   = 10;
	localparam int X_W     = 10;
	localparam int END_W   = 11;
	localparam int SIZE_W  = 11;
	localparam int INDEX_W = 19;
	localparam int RUN_W   = 11;
	localparam int THR_W   = 10;

	localparam logic [RUN_W-1:0]   RUN_MAX   = 11'd2047;
	localparam logic [INDEX_W-1:0] INDEX_MAX = 19'd524287;
	localparam logic [THR_W-1:0]   THR_RESET = 10'd4;

	// Register map, word index
	localparam logic REG_MERGE_THRESHOLD = 1'b0;

	typedef struct packed {
		logic [PIX_W-1:0] new_pixel;
		logic [PIX_W-1:0] old_pixel;
		logic [ROW_W-1:0] row;
		logic             last_in_row;
		logic             first_in_frame;
	} pix_item_t;

	typedef struct packed {
		logic [X_W-1:0]     span_x;
		logic [END_W-1:0]   span_end_x;
		logic [ROW_W-1:0]   span_row;
		logic [SIZE_W-1:0]  span_size;
		logic [INDEX_W-1:0] span_index;
	} span_t;

endpackage

// ===== rtl/core/epdsf_apb_regs.sv =====
`timescale 1ns / 1ps

module epdsf_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [2:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [epdsf_pkg::THR_W-1:0] merge_threshold
);
	import epdsf_pkg::*;

	logic hit;
	logic [THR_W-1:0] thr_q;

	assign pready = 1'b1;
	assign hit    = (paddr[2] == REG_MERGE_THRESHOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (hit) begin
			prdata = 32'(thr_q);
		end
	end

	assign merge_threshold = thr_q;

endmodule

// ===== rtl/core/epdsf_span_core.sv =====
`timescale 1ns / 1ps

module epdsf_span_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  epdsf_pkg::pix_item_t        item,
	input  logic [epdsf_pkg::THR_W-1:0] merge_threshold,
	output logic                        emit,
	output epdsf_pkg::span_t            span
);
	import epdsf_pkg::*;

	localparam int COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

	logic [COL_W-1:0]   column_q;
	logic               open_q;
	logic [COL_W-1:0]   start_q;
	logic [COL_W:0]     end_q;
	logic [RUN_W-1:0]   run_q;
	logic [INDEX_W-1:0] count_q;

	logic               differs, last_eff, thr_hit;
	logic [COL_W-1:0]   col_eff;
	logic               open0, open1;
	logic [RUN_W-1:0]   run0, run1, run_inc;
	logic [INDEX_W-1:0] count0;
	logic [COL_W-1:0]   start1;
	logic [COL_W:0]     end1, size1;

	assign differs = (item.new_pixel[CMP_W-1:0] != item.old_pixel[CMP_W-1:0]);

	// frame start restarts the row and drops any open span silently
	assign col_eff  = item.first_in_frame ? '0 : column_q;
	assign open0    = item.first_in_frame ? 1'b0 : open_q;
	assign run0     = item.first_in_frame ? '0 : run_q;
	assign count0   = item.first_in_frame ? '0 : count_q;
	assign last_eff = item.last_in_row || (col_eff >= COL_LAST);
	assign run_inc  = (run0 < RUN_MAX) ? run0 + 1'b1 : run0;

	always_comb begin
		open1   = open0;
		start1  = start_q;
		end1    = end_q;
		run1    = run0;
		thr_hit = 1'b0;
		if (!open0) begin
			if (differs) begin
				open1  = 1'b1;
				start1 = col_eff;
				end1   = {1'b0, col_eff} + 1'b1;
				run1   = '0;
			end
		end else if (differs) begin
			end1 = {1'b0, col_eff} + 1'b1;
			run1 = '0;
		end else begin
			thr_hit = (run_inc > RUN_W'(merge_threshold));
			run1    = thr_hit ? '0 : run_inc;
			open1   = !thr_hit;
		end
	end

	// one close per pixel: a threshold close leaves nothing open for the row end
	assign emit  = thr_hit || (last_eff && open1);
	assign size1 = end1 - {1'b0, start1};

	always_comb begin
		span.span_x     = X_W'(32'(start1));
		span.span_end_x = END_W'(32'(end1));
		span.span_row   = item.row;
		span.span_size  = SIZE_W'(32'(size1));
		span.span_index = count0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			open_q   <= 1'b0;
			run_q    <= '0;
			count_q  <= '0;
		end else if (advance) begin
			column_q <= last_eff ? '0 : col_eff + 1'b1;
			open_q   <= open1 && !last_eff;
			run_q    <= emit ? '0 : run1;
			count_q  <= (emit && (count0 != INDEX_MAX)) ? count0 + 1'b1 : count0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			start_q <= start1;
			end_q   <= end1;
		end
	end

endmodule

// ===== rtl/core/exact_pixel_diff_span_finder_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// pixel     in         pix_valid/pix_ready    new_pixel, old_pixel, row, last_in_row,
//                                             first_in_frame
// span      out        span_valid/span_ready  span_x, span_end_x, span_row, span_size,
//                                             span_index
// config    in         APB, pready tied high  merge_threshold at byte address 0
//
// One item per clock sustained unless a closing item meets a stalled output. An item
// is registered on accept, evaluated against the span state in the next cycle, and
// any closing span is loaded into the output register when that item advances.
// Reset clears the span flags, column, run and index counters and the output
// valid; span bounds are only read while a span is open. No clearing pass.
// A stalled span output blocks only an item that itself closes a span;
// items that close nothing keep flowing while a span waits to be taken.

module exact_pixel_diff_span_finder_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// pixel channel
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  logic [epdsf_pkg::PIX_W-1:0]   new_pixel,
	input  logic [epdsf_pkg::PIX_W-1:0]   old_pixel,
	input  logic [epdsf_pkg::ROW_W-1:0]   row,
	input  logic                          last_in_row,
	input  logic                          first_in_frame,
	// span channel
	output logic                          span_valid,
	input  logic                          span_ready,
	output logic [epdsf_pkg::X_W-1:0]     span_x,
	output logic [epdsf_pkg::END_W-1:0]   span_end_x,
	output logic [epdsf_pkg::ROW_W-1:0]   span_row,
	output logic [epdsf_pkg::SIZE_W-1:0]  span_size,
	output logic [epdsf_pkg::INDEX_W-1:0] span_index,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import epdsf_pkg::*;

	logic             valid_s1;
	pix_item_t        item_s1;
	logic             advance;
	logic             emit;
	span_t            span_c;
	logic             out_valid_q;
	span_t            out_span_q;
	logic [THR_W-1:0] merge_threshold;

	epdsf_apb_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.merge_threshold (merge_threshold)
	);

	// stage 1 item moves on unless it closes a span into a full, stalled output
	assign advance   = valid_s1 && (!emit || !out_valid_q || span_ready);
	assign pix_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_valid && pix_ready) begin
			item_s1.new_pixel      <= new_pixel;
			item_s1.old_pixel      <= old_pixel;
			item_s1.row            <= row;
			item_s1.last_in_row    <= last_in_row;
			item_s1.first_in_frame <= first_in_frame;
		end
	end

	epdsf_span_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_span (
		.clk             (clk),
		.arst_n          (arst_n),
		.advance         (advance),
		.item            (item_s1),
		.merge_threshold (merge_threshold),
		.emit            (emit),
		.span            (span_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (span_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_span_q <= span_c;
		end
	end

	assign span_valid = out_valid_q;
	assign span_x     = out_span_q.span_x;
	assign span_end_x = out_span_q.span_end_x;
	assign span_row   = out_span_q.span_row;
	assign span_size  = out_span_q.span_size;
	assign span_index = out_span_q.span_index;

endmodule

// ===== rtl/core/epdsf_checker.sv =====
`timescale 1ns / 1ps

module epdsf_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_ready,
	input logic        span_valid,
	input logic        span_ready,
	input logic [9:0]  span_x,
	input logic [10:0] span_end_x,
	input logic [10:0] span_size,
	input logic [18:0] span_index
);

	localparam bit EXACT = (MAX_WIDTH <= 1024);

	// a waiting span holds until taken
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && !span_ready |=> span_valid && $stable(span_x) &&
		$stable(span_end_x) && $stable(span_size) && $stable(span_index))
		else $error("span changed while stalled");

	// with the output register empty the pixel side is never blocked
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!span_valid |-> pix_ready)
		else $error("pixel input blocked with empty output");

	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		EXACT && span_valid |-> span_size == span_end_x - {1'b0, span_x})
		else $error("span size does not match its bounds");

	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		EXACT && span_valid |-> span_end_x > {1'b0, span_x} && span_size != 11'd0)
		else $error("empty span emitted");

endmodule

bind exact_pixel_diff_span_finder_core epdsf_checker #(.MAX_WIDTH(MAX_WIDTH)) u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_ready  (pix_ready),
	.span_valid (span_valid),
	.span_ready (span_ready),
	.span_x     (span_x),
	.span_end_x (span_end_x),
	.span_size  (span_size),
	.span_index (span_index)
);

// ===== tb/tb_exact_pixel_diff_span_finder_core.sv =====
`timescale 1ns / 1ps

module tb_exact_pixel_diff_span_finder_core;
	import epdsf_pkg::*;

	localparam int FRAME_W = 1024;
	localparam int CYCLE_LIMIT = 3_000_000;
	// spans pass the item and output registers; leave margin before idle-only actions
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASE_ITEMS = 50;
	localparam logic [2:0] THR_ADDR = {REG_MERGE_THRESHOLD, 2'b00};
	localparam logic [THR_W-1:0] THR_MAX = '1;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_ready;
	logic [PIX_W-1:0] new_pixel;
	logic [PIX_W-1:0] old_pixel;
	logic [ROW_W-1:0] row;
	logic last_in_row;
	logic first_in_frame;
	logic span_valid;
	logic span_ready;
	logic [X_W-1:0] span_x;
	logic [END_W-1:0] span_end_x;
	logic [ROW_W-1:0] span_row;
	logic [SIZE_W-1:0] span_size;
	logic [INDEX_W-1:0] span_index;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	exact_pixel_diff_span_finder_core #(
		.MAX_WIDTH(FRAME_W),
		.PIXEL_BITS(PIX_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_ready(pix_ready),
		.new_pixel(new_pixel),
		.old_pixel(old_pixel),
		.row(row),
		.last_in_row(last_in_row),
		.first_in_frame(first_in_frame),
		.span_valid(span_valid),
		.span_ready(span_ready),
		.span_x(span_x),
		.span_end_x(span_end_x),
		.span_row(span_row),
		.span_size(span_size),
		.span_index(span_index),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Span tracker mirror
	logic [THR_W-1:0] thr_m;
	logic [10:0] col_m;
	logic row_begins_m;
	logic open_m;
	logic [X_W-1:0] start_m;
	logic [END_W-1:0] end_m;
	logic [RUN_W-1:0] run_m;
	logic [INDEX_W-1:0] count_m;

	span_t spans_due[$];
	span_t span_want;

	int pixels_sent;
	int spans_seen;
	int mismatches;
	int cycle_count;
	int span_hold_cycles;
	bit gaps_on;
	bit span_stalls_on;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void close_span(input logic [ROW_W-1:0] r);
		span_t s;
		s.span_x = start_m;
		s.span_end_x = end_m;
		s.span_row = r;
		s.span_size = end_m - {1'b0, start_m};
		s.span_index = count_m;
		spans_due.push_back(s);
		if (count_m != INDEX_MAX)
			count_m++;
		open_m = 1'b0;
		run_m = '0;
	endfunction

	// Advances the mirror by one accepted pixel and queues the span it closes, if any.
	function automatic void predict_span(input pix_item_t it);
		logic at_end;
		logic differs;
		at_end = it.last_in_row;
		differs = (it.new_pixel != it.old_pixel);
		if (it.first_in_frame) begin
			open_m = 1'b0;	// open span dropped, not emitted
			run_m = '0;
			count_m = '0;
			row_begins_m = 1'b1;
		end
		if (row_begins_m) begin
			col_m = '0;
			row_begins_m = 1'b0;
		end
		if (col_m >= FRAME_W - 1) begin
			col_m = 11'(FRAME_W - 1);	// row end forced at the last column
			at_end = 1'b1;
		end
		if (!open_m) begin
			if (differs) begin
				open_m = 1'b1;
				start_m = col_m[X_W-1:0];
				end_m = col_m + 11'd1;
				run_m = '0;
			end
		end else if (differs) begin
			end_m = col_m + 11'd1;
			run_m = '0;
		end else begin
			if (run_m != RUN_MAX)
				run_m++;
			if (run_m > {1'b0, thr_m})
				close_span(it.row);
		end
		if (at_end) begin
			if (open_m)
				close_span(it.row);
			row_begins_m = 1'b1;
			col_m = '0;
		end else begin
			col_m++;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_idle_len(input bit on);
		int r;
		r = $urandom_range(0, 99);
		if (!on || r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Span checker
	always @(posedge clk) begin
		if (arst_n && span_valid && span_ready) begin
			spans_seen++;
			if (spans_due.size() == 0) begin
				$display("%0t: span with none expected, x %0d end %0d row %0d index %0d",
					$time, span_x, span_end_x, span_row, span_index);
				mismatches++;
			end else begin
				span_want = spans_due.pop_front();
				check_field("span_x", 32'(span_want.span_x), 32'(span_x));
				check_field("span_end_x", 32'(span_want.span_end_x), 32'(span_end_x));
				check_field("span_row", 32'(span_want.span_row), 32'(span_row));
				check_field("span_size", 32'(span_want.span_size), 32'(span_size));
				check_field("span_index", 32'(span_want.span_index), 32'(span_index));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d spans still expected", $time, spans_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Span receiver: random stalls, plus a long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		span_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (span_hold_cycles > 0) begin
				span_ready <= 1'b0;
				span_hold_cycles--;
			end else if (stall_left > 0) begin
				span_ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_idle_len(span_stalls_on);
				span_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after accept, valid still high.
	task automatic send_pixel(input logic [PIX_W-1:0] np, input logic [PIX_W-1:0] op,
			input logic [ROW_W-1:0] r, input bit eol, input bit sof);
		pix_item_t it;
		int gap;
		it.new_pixel = np;
		it.old_pixel = op;
		it.row = r;
		it.last_in_row = eol;
		it.first_in_frame = sof;
		gap = pick_idle_len(gaps_on);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid <= 1'b1;
		new_pixel <= np;
		old_pixel <= op;
		row <= r;
		last_in_row <= eol;
		first_in_frame <= sof;
		do @(posedge clk); while (!pix_ready);
		predict_span(it);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Random pixel pair that differs or not; differences are often a single bit
	task automatic send_px(input bit differ, input logic [ROW_W-1:0] r, input bit eol,
			input bit sof);
		logic [PIX_W-1:0] np;
		logic [PIX_W-1:0] flip;
		np = PIX_W'($urandom);
		flip = '0;
		if (differ) begin
			if ($urandom_range(0, 1))
				flip = 16'h1 << $urandom_range(0, PIX_W - 1);
			else
				flip = PIX_W'($urandom_range(1, 16'hFFFF));
		end
		send_pixel(np, np ^ flip, r, eol, sof);
	endtask

	task automatic drain_spans();
		pix_valid <= 1'b0;
		while (spans_due.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One APB transfer; leaves psel high so a second transfer can follow directly
	task automatic apb_access(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= THR_ADDR;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
	endtask

	task automatic check_threshold(input logic [THR_W-1:0] want);
		logic [31:0] got;
		apb_access(1'b0, 32'h0, got);
		psel <= 1'b0;
		penable <= 1'b0;
		check_field("merge_threshold", 32'(want), 32'(got[THR_W-1:0]));
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] value);
		logic [31:0] word;
		logic [31:0] unused;
		word = $urandom;	// bits above the register field are ignored
		word[THR_W-1:0] = value;
		drain_spans();
		apb_access(1'b1, word, unused);
		thr_m = value;
		check_threshold(value);
	endtask

	// Short directed run at the reset threshold of 4
	task automatic test_directed_cases();
		int n;
		// extreme values, frame start, span opens at column 0
		send_pixel(16'hFFFF, 16'h0000, 10'd1023, 1'b0, 1'b1);
		send_px(1'b0, 10'd1023, 1'b0, 1'b0);
		send_px(1'b1, 10'd1023, 1'b0, 1'b0);
		// five unchanged pixels exceed the threshold
		for (n = 0; n < 5; n++)
			send_px(1'b0, 10'd1023, 1'b0, 1'b0);
		send_pixel(16'hFFFF, 16'hFFFF, 10'd1023, 1'b1, 1'b0);
		// threshold and row end on the same pixel: one span
		send_pixel(16'h0000, 16'hFFFF, 10'd0, 1'b0, 1'b0);
		for (n = 0; n < 4; n++)
			send_px(1'b0, 10'd0, 1'b0, 1'b0);
		send_pixel(16'h0000, 16'h0000, 10'd0, 1'b1, 1'b0);
		// span starting mid-row, closed by row end
		send_px(1'b0, 10'd5, 1'b0, 1'b0);
		send_px(1'b1, 10'd5, 1'b0, 1'b0);
		send_px(1'b1, 10'd5, 1'b1, 1'b0);
		// frame start drops an open span and restarts the index
		send_px(1'b1, 10'd6, 1'b0, 1'b0);
		send_px(1'b0, 10'd6, 1'b0, 1'b1);
		send_px(1'b1, 10'd6, 1'b1, 1'b0);
		// single-pixel row that opens a frame with a change
		send_px(1'b1, 10'd512, 1'b1, 1'b1);
		send_px(1'b1, 10'd513, 1'b0, 1'b0);
		send_px(1'b1, 10'd513, 1'b1, 1'b0);
	endtask

	// A single unchanged pixel closes the span
	task automatic test_zero_threshold();
		set_threshold('0);
		send_px(1'b1, 10'd3, 1'b0, 1'b1);
		send_px(1'b0, 10'd3, 1'b0, 1'b0);
		send_px(1'b1, 10'd3, 1'b0, 1'b0);
		send_px(1'b1, 10'd3, 1'b0, 1'b0);
		send_px(1'b0, 10'd3, 1'b0, 1'b0);
		send_px(1'b0, 10'd3, 1'b0, 1'b0);
		send_px(1'b1, 10'd3, 1'b1, 1'b0);
	endtask

	// One row of full width without a row-end marker, at the largest threshold
	task automatic test_full_width_rows();
		int col;
		set_threshold(THR_MAX);
		gaps_on = 1'b0;
		// changes at both edges: span covers the whole row, end forced at the last column
		for (col = 0; col < FRAME_W; col++)
			send_px(col == 0 || col == FRAME_W - 1, 10'd100, 1'b0, col == 0);
		gaps_on = 1'b1;
	endtask

	// Receiver holds off while every other pixel closes a span; input must stall
	task automatic test_output_backpressure();
		int n;
		set_threshold('0);
		gaps_on = 1'b0;
		span_stalls_on = 1'b0;
		span_hold_cycles = 300;
		for (n = 0; n < 80; n++)
			send_px(n % 2 == 0, 10'd77, n % 10 == 9, n == 0);
		// sender waits here until every span has been taken
		drain_spans();
		gaps_on = 1'b1;
		span_stalls_on = 1'b1;
	endtask

	// Well-formed frames with random content under several thresholds, some noise mixed in
	task automatic test_random_frames();
		int k;
		int sent;
		int rows;
		int ri;
		int width;
		int col;
		int density;
		int r;
		logic [THR_W-1:0] thr;
		logic [ROW_W-1:0] row_no;
		for (k = 0; k < 7; k++) begin
			case (k)
				0: thr = 10'd1;
				1: thr = 10'd3;
				2: thr = 10'd0;
				3: thr = THR_W'($urandom_range(5, 40));
				4: thr = THR_W'($urandom_range(0, 1023));
				5: thr = THR_MAX;
				default: thr = 10'd2;
			endcase
			set_threshold(thr);
			// every third phase runs with no idling on either side
			gaps_on = (k % 3 != 1);
			span_stalls_on = (k % 3 != 1);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				row_no = ROW_W'($urandom);
				rows = $urandom_range(1, 6);
				for (ri = 0; ri < rows && sent < PHASE_ITEMS; ri++) begin
					r = $urandom_range(0, 99);
					if (r < 80)
						width = $urandom_range(2, 24);
					else if (r < 95)
						width = $urandom_range(25, 120);
					else if (r < 99)
						width = 1;
					else
						width = $urandom_range(121, 400);
					case ($urandom_range(0, 3))
						0: density = 5;
						1: density = 20;
						2: density = 50;
						default: density = 90;
					endcase
					for (col = 0; col < width; col++) begin
						if ($urandom_range(0, 99) < 6)
							send_px($urandom_range(0, 1) == 1, ROW_W'($urandom),
								$urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
						else
							send_px($urandom_range(0, 99) < density, row_no,
								col == width - 1, ri == 0 && col == 0);
						sent++;
					end
					row_no++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pix_valid = 1'b0;
		new_pixel = '0;
		old_pixel = '0;
		row = '0;
		last_in_row = 1'b0;
		first_in_frame = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gaps_on = 1'b1;
		span_stalls_on = 1'b1;
		span_hold_cycles = 0;
		pixels_sent = 0;
		spans_seen = 0;
		mismatches = 0;
		cycle_count = 0;
		thr_m = THR_RESET;
		col_m = '0;
		row_begins_m = 1'b1;
		open_m = 1'b0;
		start_m = '0;
		end_m = '0;
		run_m = '0;
		count_m = '0;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		check_threshold(THR_RESET);
		test_directed_cases();
		test_zero_threshold();
		test_full_width_rows();
		test_output_backpressure();
		test_random_frames();
		drain_spans();

		$display("Sent %0d pixel items and checked %0d spans", pixels_sent, spans_seen);
		$display("Thresholds 0 to 1023, a full-width row, frame restarts and output hold-off");
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/epdsf_pkg.sv
rtl/core/epdsf_apb_regs.sv
rtl/core/epdsf_span_core.sv
rtl/core/exact_pixel_diff_span_finder_core.sv
rtl/core/epdsf_checker.sv
tb/tb_exact_pixel_diff_span_finder_core.sv
